// ----- src/bfha_pkg.sv -----
// Package for the best-fit heap allocator.
// Holds register widths, codes and the sequencer state type; no dependencies.
package bfha_pkg;

  localparam int HDR_W   = 7;
  localparam int PAGE_W  = 17;
  localparam int LIMIT_W = 21;
  localparam int CFG_W   = 21;
  localparam int CIDX_W  = 2;

  typedef enum logic [CIDX_W-1:0] {
    REG_HEADER = 2'd0,
    REG_PAGE   = 2'd1,
    REG_LIMIT  = 2'd2
  } reg_idx_t;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_HEAP   = 2'd1,
    ST_BAD_ADDR  = 2'd2,
    ST_TABLE_FULL = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_DIV,
    S_GROW,
    S_NEXT,
    S_SHIFT,
    S_WR1,
    S_WR2,
    S_RESP
  } state_t;

endpackage

// ----- src/bfha_if.sv -----
// Request and response channel interfaces of the best-fit heap allocator.
// Valid/ready handshake; no package dependency.
interface bfha_req_if #(parameter int ADDR_BITS = 20);
  logic                 valid;
  logic                 ready;
  logic                 opcode;
  logic [ADDR_BITS-1:0] request_bytes;
  logic [ADDR_BITS-1:0] block_address;
  modport source(output valid, opcode, request_bytes, block_address, input ready);
  modport sink(input valid, opcode, request_bytes, block_address, output ready);
endinterface

interface bfha_rsp_if #(parameter int ADDR_BITS = 20);
  logic                 valid;
  logic                 ready;
  logic [ADDR_BITS-1:0] data_address;
  logic [1:0]           status;
  logic [ADDR_BITS:0]   retained_total;
  modport source(output valid, data_address, status, retained_total, input ready);
  modport sink(input valid, data_address, status, retained_total, output ready);
endinterface

// ----- src/bfha_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module bfha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/best_fit_heap_allocator.sv -----
// Best-fit heap allocator top level; uses bfha_pkg, bfha_req_if/bfha_rsp_if, bfha_ram.
// Segment table held in one RAM of {busy, size}; a sequencer scans, divides and shifts.
//
// One transaction at a time. An exact-fit allocate runs the best-fit scan (one RAM read per
// segment), a decide state and a write state. A split adds a second write state and a
// shift pass that moves the entries behind it up. Growing the heap adds the page division,
// the limit check and the second write state. A free scans to the segment at index k, then
// runs a shift pass that moves entries down when merges occur, and its write; an unknown
// address ends after the scan. Results sit in an output register; the next request is
// taken once the sequencer is back in idle.
module best_fit_heap_allocator #(
  parameter int MAX_SEGMENTS = 64,
  parameter int ADDR_BITS    = 20
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [bfha_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [bfha_pkg::CFG_W-1:0]    cfg_data,
  bfha_req_if.sink                      in_ch,
  bfha_rsp_if.source                    out_ch
);

  localparam int IW  = $clog2(MAX_SEGMENTS);
  localparam int CW  = $clog2(MAX_SEGMENTS + 1);
  localparam int SW  = ADDR_BITS;
  localparam int EW  = ADDR_BITS + 1;
  localparam int OW  = ADDR_BITS + 2;
  localparam int NW  = ADDR_BITS + 1;
  localparam int LW  = (ADDR_BITS + 3 > 23) ? ADDR_BITS + 3 : 23;
  localparam int DCW = $clog2(NW + 1);
  localparam int PW  = bfha_pkg::PAGE_W;

  logic [bfha_pkg::HDR_W-1:0]   header_bytes;
  logic [PW-1:0]                page_bytes;
  logic [bfha_pkg::LIMIT_W-1:0] heap_limit;

  bfha_pkg::state_t state, state_next;

  logic [CW-1:0]        cnt;
  logic [ADDR_BITS:0]   retained;
  logic                 op;
  logic [SW-1:0]        req;
  logic [SW-1:0]        addr;
  logic [IW-1:0]        k;
  logic [OW-1:0]        off;
  logic                 found;
  logic [IW-1:0]        best;
  logic [SW-1:0]        best_sz;
  logic [OW-1:0]        best_off;
  logic                 prev_busy;
  logic [SW-1:0]        prev_sz;
  logic [SW-1:0]        cur_sz;
  logic [NW-1:0]        dnum;
  logic [PW-1:0]        drem;
  logic [DCW-1:0]       diter;
  logic [IW-1:0]        sp;
  logic [CW-1:0]        nleft;
  logic                 sdir_up;
  logic [1:0]           sdist;
  logic                 pv;
  logic [IW-1:0]        pa;
  logic [IW-1:0]        w1_addr;
  logic [EW-1:0]        w1_data;
  logic                 w2_en;
  logic [IW-1:0]        w2_addr;
  logic [EW-1:0]        w2_data;
  logic [1:0]           st;

  logic                 ram_we;
  logic [IW-1:0]        ram_waddr;
  logic [EW-1:0]        ram_wdata;
  logic [IW-1:0]        ram_raddr;
  logic [EW-1:0]        ram_rdata;

  logic                 r_busy;
  logic [SW-1:0]        r_sz;
  logic [SW:0]          req_h;
  logic [OW-1:0]        off_inc;
  logic                 fit;
  logic                 last;
  logic [PW-1:0]        page_eff;
  logic [PW:0]          dtrial;
  logic [NW-1:0]        num;
  logic [LW-1:0]        grow;
  logic [LW-1:0]        lim;

  bfha_ram #(.WIDTH(EW), .DEPTH(MAX_SEGMENTS)) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign r_busy   = ram_rdata[EW-1];
  assign r_sz     = ram_rdata[SW-1:0];
  assign req_h    = {1'b0, req} + (SW+1)'(header_bytes);
  assign off_inc  = off + OW'(header_bytes) + OW'(r_sz);
  assign fit      = !r_busy && ((req == r_sz) || (req_h < {1'b0, r_sz}))
                    && (!found || (r_sz <= best_sz));
  assign last     = (CW'(k) + CW'(1)) >= cnt;
  assign page_eff = (page_bytes == '0) ? PW'(1) : page_bytes;
  assign dtrial   = {drem, dnum[NW-1]};
  assign num      = NW'(header_bytes) + NW'(header_bytes) + NW'(req);
  assign grow     = LW'(num) - LW'(drem) + LW'(page_eff);
  assign lim      = (LW'(heap_limit) < (LW'(1) << ADDR_BITS)) ? LW'(heap_limit)
                                                              : (LW'(1) << ADDR_BITS);

  assign in_ch.ready = (state == bfha_pkg::S_IDLE);

  always_comb begin
    ram_raddr = '0;
    ram_we    = 1'b0;
    ram_waddr = w1_addr;
    ram_wdata = w1_data;
    case (state)
      bfha_pkg::S_SCAN:  ram_raddr = k + IW'(1);
      bfha_pkg::S_SHIFT: ram_raddr = sp;
      default:           ram_raddr = '0;
    endcase
    case (state)
      bfha_pkg::S_SHIFT: begin
        ram_we    = pv;
        ram_waddr = sdir_up ? pa + IW'(1) : pa - IW'(sdist);
        ram_wdata = ram_rdata;
      end
      bfha_pkg::S_WR1: ram_we = 1'b1;
      bfha_pkg::S_WR2: begin
        ram_we    = 1'b1;
        ram_waddr = w2_addr;
        ram_wdata = w2_data;
      end
      default: ram_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_bytes <= bfha_pkg::HDR_W'(32);
      page_bytes   <= PW'(4096);
      heap_limit   <= bfha_pkg::LIMIT_W'(1048576);
    end else if (cfg_we) begin
      case (cfg_index)
        bfha_pkg::REG_HEADER: header_bytes <= cfg_data[bfha_pkg::HDR_W-1:0];
        bfha_pkg::REG_PAGE:   page_bytes   <= cfg_data[PW-1:0];
        bfha_pkg::REG_LIMIT:  heap_limit   <= cfg_data[bfha_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bfha_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      bfha_pkg::S_IDLE: begin
        if (in_ch.valid) begin
          state_next = (cnt == '0) ? ((in_ch.opcode == bfha_pkg::OP_ALLOC) ?
                       bfha_pkg::S_DECIDE : bfha_pkg::S_RESP) : bfha_pkg::S_SCAN;
        end
      end
      bfha_pkg::S_SCAN: begin
        if (op == bfha_pkg::OP_FREE && off == OW'(addr)) begin
          state_next = bfha_pkg::S_NEXT;
        end else if (last) begin
          state_next = (op == bfha_pkg::OP_ALLOC) ? bfha_pkg::S_DECIDE : bfha_pkg::S_RESP;
        end
      end
      bfha_pkg::S_DECIDE: begin
        if (found) begin
          if (req < best_sz) begin
            state_next = (cnt >= CW'(MAX_SEGMENTS)) ? bfha_pkg::S_RESP : bfha_pkg::S_SHIFT;
          end else begin
            state_next = bfha_pkg::S_WR1;
          end
        end else begin
          state_next = ((cnt + CW'(2)) > CW'(MAX_SEGMENTS) || cnt >= CW'(MAX_SEGMENTS))
                       ? bfha_pkg::S_RESP : bfha_pkg::S_DIV;
        end
      end
      bfha_pkg::S_DIV:   if (diter == '0) state_next = bfha_pkg::S_GROW;
      bfha_pkg::S_GROW: begin
        state_next = ((LW'(retained) + grow) > lim) ? bfha_pkg::S_RESP : bfha_pkg::S_WR1;
      end
      bfha_pkg::S_NEXT:  state_next = bfha_pkg::S_SHIFT;
      bfha_pkg::S_SHIFT: if (nleft == '0 && !pv) state_next = bfha_pkg::S_WR1;
      bfha_pkg::S_WR1:   state_next = w2_en ? bfha_pkg::S_WR2 : bfha_pkg::S_RESP;
      bfha_pkg::S_WR2:   state_next = bfha_pkg::S_RESP;
      bfha_pkg::S_RESP:  if (!out_ch.valid || out_ch.ready) state_next = bfha_pkg::S_IDLE;
      default:           state_next = bfha_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt          <= '0;
      retained     <= '0;
      out_ch.valid <= 1'b0;
      pv           <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready && state != bfha_pkg::S_RESP) begin
        out_ch.valid <= 1'b0;
      end
      case (state)
        bfha_pkg::S_IDLE: begin
          op      <= in_ch.opcode;
          req     <= in_ch.request_bytes;
          addr    <= in_ch.block_address;
          k       <= '0;
          off     <= OW'(header_bytes);
          found   <= 1'b0;
          best    <= '0;
          best_sz <= '0;
          prev_busy <= 1'b1;
          prev_sz <= '0;
          w2_en   <= 1'b0;
          pv      <= 1'b0;
          st      <= (in_ch.opcode == bfha_pkg::OP_ALLOC) ? bfha_pkg::ST_OK
                                                          : bfha_pkg::ST_BAD_ADDR;
        end
        bfha_pkg::S_SCAN: begin
          if (op == bfha_pkg::OP_FREE) begin
            if (off == OW'(addr)) begin
              cur_sz <= r_sz;
              st     <= bfha_pkg::ST_OK;
            end else begin
              prev_busy <= r_busy;
              prev_sz   <= r_sz;
              off       <= off_inc;
              k         <= k + IW'(1);
            end
          end else begin
            if (fit) begin
              found    <= 1'b1;
              best     <= k;
              best_sz  <= r_sz;
              best_off <= off;
            end
            off <= off_inc;
            k   <= k + IW'(1);
          end
        end
        bfha_pkg::S_DECIDE: begin
          if (found) begin
            if (req < best_sz) begin
              if (cnt >= CW'(MAX_SEGMENTS)) begin
                st <= bfha_pkg::ST_TABLE_FULL;
              end else begin
                sdir_up <= 1'b1;
                sp      <= cnt[IW-1:0] - IW'(1);
                nleft   <= cnt - CW'(best) - CW'(1);
                cnt     <= cnt + CW'(1);
                w1_addr <= best;
                w1_data <= {1'b1, req};
                w2_en   <= 1'b1;
                w2_addr <= best + IW'(1);
                w2_data <= {1'b0, SW'(best_sz - req - SW'(header_bytes))};
              end
            end else begin
              w1_addr <= best;
              w1_data <= {1'b1, best_sz};
            end
          end else if ((cnt + CW'(2)) > CW'(MAX_SEGMENTS) || cnt >= CW'(MAX_SEGMENTS)) begin
            st <= bfha_pkg::ST_TABLE_FULL;
          end else begin
            dnum  <= num;
            drem  <= '0;
            diter <= DCW'(NW);
          end
        end
        bfha_pkg::S_DIV: begin
          if (diter != '0) begin
            drem  <= (dtrial >= {1'b0, page_eff}) ? PW'(dtrial - {1'b0, page_eff})
                                                  : dtrial[PW-1:0];
            dnum  <= {dnum[NW-2:0], 1'b0};
            diter <= diter - DCW'(1);
          end
        end
        bfha_pkg::S_GROW: begin
          if ((LW'(retained) + grow) > lim) begin
            st <= bfha_pkg::ST_NO_HEAP;
          end else begin
            retained <= (ADDR_BITS+1)'(LW'(retained) + grow);
            best     <= cnt[IW-1:0];
            best_off <= off;
            w1_addr  <= cnt[IW-1:0];
            w1_data  <= {1'b1, req};
            w2_en    <= 1'b1;
            w2_addr  <= cnt[IW-1:0] + IW'(1);
            w2_data  <= {1'b0, SW'(grow - LW'(header_bytes) - LW'(req)
                                    - LW'(header_bytes))};
            cnt      <= cnt + CW'(2);
          end
        end
        bfha_pkg::S_NEXT: begin
          begin
            logic          m, p;
            logic [SW-1:0] nsz;
            m   = ((CW'(k) + CW'(1)) < cnt) && !r_busy;
            p   = (k != '0) && !prev_busy;
            nsz = (p ? prev_sz + SW'(header_bytes) : '0) + cur_sz
                  + (m ? SW'(header_bytes) + r_sz : '0);
            w1_addr <= p ? k - IW'(1) : k;
            w1_data <= {1'b0, nsz};
            sdir_up <= 1'b0;
            sdist   <= 2'(m) + 2'(p);
            sp      <= k + IW'(1) + IW'(m);
            nleft   <= (m || p) ? cnt - CW'(k) - CW'(1) - CW'(m) : '0;
            cnt     <= cnt - CW'(m) - CW'(p);
          end
        end
        bfha_pkg::S_SHIFT: begin
          pv <= (nleft != '0);
          pa <= sp;
          if (nleft != '0) begin
            sp    <= sdir_up ? sp - IW'(1) : sp + IW'(1);
            nleft <= nleft - CW'(1);
          end
        end
        bfha_pkg::S_RESP: begin
          if (!out_ch.valid || out_ch.ready) begin
            out_ch.valid          <= 1'b1;
            out_ch.status         <= st;
            out_ch.data_address   <= (st == bfha_pkg::ST_OK && op == bfha_pkg::OP_ALLOC)
                                     ? best_off[ADDR_BITS-1:0] : '0;
            out_ch.retained_total <= retained;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ----- sim/bfha_checker.sv -----
`timescale 1ns / 1ps
// Checker for the best-fit heap allocator: watches both channels, predicts each response
// from its own segment table model and compares field by field. Depends on bfha_pkg, bfha_if.
module bfha_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [20:0] cfg_data,
  bfha_req_if        in_ch,
  bfha_rsp_if        out_ch,
  output int         fail_count,
  output int         pending
);

  typedef struct packed {
    logic [19:0]       addr;
    bfha_pkg::status_t st;
    logic [20:0]       total;
  } alloc_rsp_t;

  localparam int NSEG = 64;

  alloc_rsp_t expected_q[$];
  longint hdr, page, limit;
  longint seg_size[NSEG];
  bit     seg_busy[NSEG];
  int     seg_cnt;
  longint retained;

  function automatic longint data_addr(int idx);
    longint off;
    off = 0;
    for (int k = 0; k < idx; k++) off += hdr + seg_size[k];
    return off + hdr;
  endfunction

  function automatic void drop_entry(int idx);
    for (int k = idx; k + 1 < seg_cnt; k++) begin
      seg_size[k] = seg_size[k+1];
      seg_busy[k] = seg_busy[k+1];
    end
    seg_cnt--;
  endfunction

  function automatic bfha_pkg::status_t heap_alloc(longint req, output longint addr);
    int best;
    bit found;
    longint pg, grow, lim, rem;
    best = 0;
    found = 0;
    addr = 0;
    for (int k = 0; k < seg_cnt; k++) begin
      if (!seg_busy[k] && (req == seg_size[k] || req + hdr < seg_size[k]) &&
          (!found || seg_size[k] <= seg_size[best])) begin
        best = k;
        found = 1;
      end
    end
    if (!found) begin
      pg = (page != 0) ? page : 1;
      if (seg_cnt + 2 > NSEG) return bfha_pkg::ST_TABLE_FULL;
      grow = ((2 * hdr + req) / pg + 1) * pg;
      lim = (limit < (64'd1 << 20)) ? limit : (64'd1 << 20);
      if (retained + grow > lim) return bfha_pkg::ST_NO_HEAP;
      retained += grow;
      best = seg_cnt;
      seg_size[best] = grow - hdr;
      seg_busy[best] = 0;
      seg_cnt++;
    end else if (req < seg_size[best] && seg_cnt >= NSEG) begin
      return bfha_pkg::ST_TABLE_FULL;
    end
    if (req < seg_size[best]) begin
      rem = seg_size[best] - req - hdr;
      for (int k = seg_cnt; k > best + 1; k--) begin
        seg_size[k] = seg_size[k-1];
        seg_busy[k] = seg_busy[k-1];
      end
      seg_size[best+1] = rem;
      seg_busy[best+1] = 0;
      seg_cnt++;
      seg_size[best] = req;
    end
    seg_busy[best] = 1;
    addr = data_addr(best);
    return bfha_pkg::ST_OK;
  endfunction

  function automatic bfha_pkg::status_t heap_free(longint a);
    longint off;
    int k;
    off = hdr;
    for (k = 0; k < seg_cnt; k++) begin
      if (off == a) break;
      off += hdr + seg_size[k];
    end
    if (k >= seg_cnt) return bfha_pkg::ST_BAD_ADDR;
    seg_busy[k] = 0;
    if (k + 1 < seg_cnt && !seg_busy[k+1]) begin
      seg_size[k] += hdr + seg_size[k+1];
      drop_entry(k + 1);
    end
    if (k > 0 && !seg_busy[k-1]) begin
      seg_size[k-1] += hdr + seg_size[k];
      drop_entry(k);
    end
    return bfha_pkg::ST_OK;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  always @(posedge clk) begin
    alloc_rsp_t e;
    longint a;
    bfha_pkg::status_t s;
    if (rst) begin
      hdr = 32; page = 4096; limit = 1048576;
      seg_cnt = 0; retained = 0;
      expected_q.delete();
      fail_count = 0;
      pending = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          bfha_pkg::REG_HEADER: hdr = longint'(cfg_data[6:0]);
          bfha_pkg::REG_PAGE:   page = longint'(cfg_data[16:0]);
          bfha_pkg::REG_LIMIT:  limit = longint'(cfg_data);
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        a = 0;
        if (in_ch.opcode == bfha_pkg::OP_ALLOC) s = heap_alloc(in_ch.request_bytes, a);
        else s = heap_free(in_ch.block_address);
        e.addr = (s == bfha_pkg::ST_OK && in_ch.opcode == bfha_pkg::OP_ALLOC) ? a[19:0] : '0;
        e.st = s;
        e.total = retained[20:0];
        expected_q.push_back(e);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          report("unexpected transaction", 0, 0);
        end else begin
          e = expected_q.pop_front();
          if (out_ch.data_address !== e.addr) report("data_address", out_ch.data_address, e.addr);
          if (out_ch.status !== e.st) report("status", out_ch.status, e.st);
          if (out_ch.retained_total !== e.total)
            report("retained_total", out_ch.retained_total, e.total);
        end
      end
      pending = expected_q.size();
    end
  end
endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// Top of the best-fit heap allocator testbench: clock, reset, stimulus and verdict.
// Depends on bfha_pkg, bfha_if, best_fit_heap_allocator and bfha_checker.
module tb;

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_we = 0;
  logic [1:0]  cfg_index = '0;
  logic [20:0] cfg_data = '0;
  int          fail_count, pending;
  int          idle_cycles = 0;
  bit          hold_rsp = 0;
  bit          done = 0;
  logic [19:0] granted[$];

  bfha_req_if #(20) in_ch();
  bfha_rsp_if #(20) out_ch();

  best_fit_heap_allocator dut (.clk, .rst, .cfg_we, .cfg_index, .cfg_data,
                               .in_ch(in_ch.sink), .out_ch(out_ch.source));
  bfha_checker chk (.clk, .rst, .cfg_we, .cfg_index, .cfg_data, .in_ch, .out_ch,
                    .fail_count, .pending);

  always #4 clk = ~clk;

  initial begin
    in_ch.valid = 0;
    in_ch.opcode = bfha_pkg::OP_ALLOC;
    in_ch.request_bytes = '0;
    in_ch.block_address = '0;
    out_ch.ready = 0;
  end

  // receiver: own stall pattern, long hold-off on request
  always @(negedge clk) begin
    int mode;
    if (hold_rsp) out_ch.ready <= 0;
    else begin
      mode = int'(($time / 5000) % 3);
      if (mode == 0) out_ch.ready <= 1;
      else if (mode == 1) out_ch.ready <= ($urandom_range(0, 3) != 0);
      else out_ch.ready <= ($urandom_range(0, 1) == 0);
    end
  end

  always @(posedge clk) begin
    if (out_ch.valid && out_ch.ready && out_ch.status == bfha_pkg::ST_OK &&
        out_ch.data_address != 0)
      granted.push_back(out_ch.data_address);
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send(logic op, logic [19:0] req, logic [19:0] a);
    in_ch.valid <= 1;
    in_ch.opcode <= op;
    in_ch.request_bytes <= req;
    in_ch.block_address <= a;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic gap();
    in_ch.valid <= 0;
    repeat ($urandom_range(1, 6)) @(negedge clk);
    in_ch.valid <= 0;
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  task automatic write_reg(bfha_pkg::reg_idx_t idx, logic [20:0] v);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 0;
  endtask

  task automatic random_phase(int n, int max_req);
    int burst;
    logic [19:0] a;
    int pick;
    burst = 0;
    for (int i = 0; i < n; i++) begin
      if (burst == 0) begin
        if ($urandom_range(0, 2) == 0) gap();
        burst = $urandom_range(1, 20);
      end
      burst--;
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
        send(bfha_pkg::OP_ALLOC, 20'($urandom_range(0, max_req)), '0);
      end else if (pick < 9 && granted.size() > 0) begin
        pick = $urandom_range(0, granted.size() - 1);
        a = granted[pick];
        granted.delete(pick);
        send(bfha_pkg::OP_FREE, '0, a);
      end else begin
        send(1'($urandom_range(0, 1)), 20'($urandom()), 20'($urandom()));
      end
    end
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst <= 0;
    @(negedge clk);
    // directed: extremes, exact fit, split, merge, unknown address, out of heap
    send(bfha_pkg::OP_ALLOC, 20'd0, 20'd0);
    send(bfha_pkg::OP_ALLOC, 20'd100, 20'd0);
    send(bfha_pkg::OP_ALLOC, 20'hFFFFF, 20'd0);
    send(bfha_pkg::OP_FREE, 20'd0, 20'd32);
    send(bfha_pkg::OP_FREE, 20'd0, 20'd32);
    send(bfha_pkg::OP_FREE, 20'd0, 20'hFFFFF);
    send(bfha_pkg::OP_FREE, 20'd0, 20'h12345);
    send(bfha_pkg::OP_ALLOC, 20'd0, 20'd0);
    send(bfha_pkg::OP_ALLOC, 20'd4000, 20'd0);
    send(bfha_pkg::OP_ALLOC, 20'h7FFFF, 20'd0);
    send(bfha_pkg::OP_FREE, 20'd0, 20'd96);
    send(bfha_pkg::OP_ALLOC, 20'd50, 20'd0);
    drain();
    write_reg(bfha_pkg::REG_HEADER, 21'd0);
    write_reg(bfha_pkg::REG_PAGE, 21'd16);
    write_reg(bfha_pkg::REG_LIMIT, 21'd0);
    send(bfha_pkg::OP_ALLOC, 20'd1, 20'd0);
    drain();
    write_reg(bfha_pkg::REG_PAGE, 21'd0);
    write_reg(bfha_pkg::REG_LIMIT, 21'h100000);
    for (int i = 0; i < 8; i++) send(bfha_pkg::OP_ALLOC, 20'(i), 20'd0);
    drain();
    // fill the table, pausing the receiver at the start while requests keep coming
    write_reg(bfha_pkg::REG_HEADER, 21'd8);
    write_reg(bfha_pkg::REG_PAGE, 21'd64);
    fork
      begin
        hold_rsp = 1;
        repeat (400) @(negedge clk);
        hold_rsp = 0;
      end
      for (int i = 0; i < 80; i++)
        send(bfha_pkg::OP_ALLOC, 20'($urandom_range(0, 40)), 20'd0);
    join
    drain();
    random_phase(400, 300);
    drain();
    write_reg(bfha_pkg::REG_HEADER, 21'd64);
    write_reg(bfha_pkg::REG_PAGE, 21'd65536);
    write_reg(bfha_pkg::REG_LIMIT, 21'h1FFFFF);
    random_phase(400, 20000);
    drain();
    write_reg(bfha_pkg::REG_HEADER, 21'($urandom_range(0, 64)));
    write_reg(bfha_pkg::REG_PAGE, 21'($urandom_range(16, 2048)));
    write_reg(bfha_pkg::REG_LIMIT, 21'($urandom_range(4096, 200000)));
    random_phase(450, 3000);
    drain();
    write_reg(bfha_pkg::REG_HEADER, 21'd32);
    write_reg(bfha_pkg::REG_PAGE, 21'd4096);
    write_reg(bfha_pkg::REG_LIMIT, 21'h100000);
    random_phase(350, 20'hFFFFF);
    drain();
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule
